// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

  // width of the tested value inside the datapath
  localparam int NUMBER_BITS = 16;

  // stream field widths
  localparam int NUMBER_W  = 16;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 8;

  localparam int VAL_W  = NUMBER_BITS;
  localparam int EXT_W  = (NUMBER_W > VAL_W) ? NUMBER_W : VAL_W;
  localparam int SQ_W   = VAL_W + 2;
  localparam int CNT_W  = $clog2(VAL_W + 1);

endpackage

// ===== rtl/trial_division_primality_test_unit.sv =====
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata[15:0] = number
// m_*     | out | m_tvalid/m_tready  | m_tdata[7:0]  = prime flag (bit 0), zero fill
//
// One item at a time. Values 0 and 1 go straight to DONE. Otherwise each trial
// divisor d = 2, 3, ... with d*d <= number takes the d*d bound check in CHECK,
// then the bit-serial remainder unit steps through every bit of the number in DIV.
// The search ends at the first divisor found or when d*d passes the number;
// worst case 254 divisors for 16-bit primes.
// rst is synchronous and clears control state only. A stalled result waits in
// the output register; the next number is taken while it waits.
module trial_division_primality_test_unit import tdpt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] number
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // [0] prime flag, [7:1] zero
);

  typedef enum logic [1:0] {IDLE, CHECK, DIV, DONE} state_t;

  state_t             state;
  logic [VAL_W-1:0]   val;
  logic [VAL_W-1:0]   shreg;
  logic [VAL_W-1:0]   rem;
  logic [VAL_W-1:0]   d;
  logic [SQ_W-1:0]    sq;
  logic [CNT_W-1:0]   cnt;
  logic               prime;
  logic               out_prime;

  logic [EXT_W-1:0]   in_ext;
  logic [VAL_W-1:0]   in_val;
  logic               s_acc;
  logic [VAL_W:0]     trial;
  logic [VAL_W-1:0]   rem_next;
  logic               out_free;

  assign in_ext   = EXT_W'(s_tdata);
  assign in_val   = in_ext[VAL_W-1:0];
  assign s_tready = (state == IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // one restoring step: shift next dividend bit in, subtract if it fits
  assign trial    = {rem, shreg[VAL_W-1]};
  assign rem_next = (trial >= {1'b0, d}) ? VAL_W'(trial - {1'b0, d}) : trial[VAL_W-1:0];

  assign m_tdata  = M_DATA_W'(out_prime);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // DONE reloads the output register itself
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_acc) begin
            val <= in_val;
            d   <= VAL_W'(2);
            sq  <= SQ_W'(4);
            if (in_val < VAL_W'(2)) begin
              prime <= 1'b0;
              state <= DONE;
            end else begin
              state <= CHECK;
            end
          end
        end
        CHECK: begin
          if (sq > SQ_W'(val)) begin
            prime <= 1'b1;
            state <= DONE;
          end else begin
            shreg <= val;
            rem   <= '0;
            cnt   <= CNT_W'(VAL_W - 1);
            state <= DIV;
          end
        end
        DIV: begin
          shreg <= shreg << 1;
          rem   <= rem_next;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            if (rem_next == '0) begin
              prime <= 1'b0;
              state <= DONE;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              sq    <= sq + SQ_W'({d, 1'b1});
              d     <= d + 1'b1;
              state <= CHECK;
            end
          end
        end
        DONE: begin
          if (out_free) begin
            out_prime <= prime;
            m_tvalid  <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_small_not_prime: assert property (@(posedge clk) disable iff (rst)
    (s_acc && in_val < VAL_W'(2)) |=> (state == DONE && !prime))
    else $error("0 or 1 not reported as non-prime");

  a_div_low: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |-> (d >= VAL_W'(2)))
    else $error("trial divisor below 2");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |-> (rem < d))
    else $error("partial remainder not below divisor");

  a_square: assert property (@(posedge clk) disable iff (rst)
    (state == CHECK) |-> (sq == SQ_W'(SQ_W'(d) * SQ_W'(d))))
    else $error("running square out of step with divisor");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tdpt_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // [15:0] number
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // [0] prime flag, [7:1] zero

  typedef struct packed {
    logic [S_DATA_W-1:0] number;
    logic                verdict;
  } pending_verdict_t;

  class verdict_board;
    pending_verdict_t verdict_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      primes;

    function new();
      mismatches = 0;
      checked    = 0;
      primes     = 0;
    endfunction

    // trial division over 2..isqrt(v), stopping at the first divisor
    static function logic prime_by_trial(logic [S_DATA_W-1:0] n);
      longint unsigned v;
      longint unsigned d;
      v = n & ((64'd1 << NUMBER_BITS) - 1);
      if (v < 2) return 1'b0;
      for (d = 2; d * d <= v; d++) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [S_DATA_W-1:0] n);
      pending_verdict_t p;
      p.number  = n;
      p.verdict = prime_by_trial(n);
      if (p.verdict) primes++;
      verdict_q.push_back(p);
    endfunction

    function void check_verdict(logic [M_DATA_W-1:0] data);
      pending_verdict_t p;
      logic [M_DATA_W-1:0] want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transfer, tdata %h", $time, data);
        mismatches++;
        return;
      end
      p    = verdict_q.pop_front();
      want = {{(M_DATA_W-1){1'b0}}, p.verdict};
      checked++;
      if (data !== want) begin
        $display("%0t: number %0d: expected tdata %h, got %h",
                 $time, p.number, want, data);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  verdict_board board = new();
  bit           tx_gapless = 1'b0;
  bit           rx_gapless = 1'b0;
  int unsigned  sent = 0;

  trial_division_primality_test_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // worst case is ~140 primes plus gaps: ~2.5 ms
  initial begin
    #12_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, board.pending());
    $display("tb: failure");
    $finish;
  end

  task automatic send_number(input logic [S_DATA_W-1:0] n);
    int unsigned gap;
    gap = tx_gapless ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= n;
    do @(posedge clk); while (!s_tready);
    board.note_number(n);
    sent++;
  endtask

  task automatic drain_verdicts();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [S_DATA_W-1:0] pick_number();
    int unsigned a;
    int unsigned b;
    case ($urandom_range(0, 9))
      0, 1:    return S_DATA_W'($urandom_range(0, 300));
      2, 3, 4: return S_DATA_W'($urandom());
      5: begin
        // perfect square: for a prime a the search runs right up to the bound
        a = $urandom_range(2, 255);
        return S_DATA_W'(a * a);
      end
      6, 7: begin
        // two factors from 128 to 255: composite, but not always free of small divisors
        a = $urandom_range(128, 255);
        b = $urandom_range(128, 255);
        return S_DATA_W'(a * b);
      end
      default: return S_DATA_W'(16'hffff - $urandom_range(0, 300));
    endcase
  endfunction

  // result side
  initial begin
    int unsigned stall;
    wait (!rst);
    forever begin
      stall = rx_gapless ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_verdict(m_tdata);
    end
  end

  initial begin
    logic [S_DATA_W-1:0] directed[$];
    int unsigned         chunk;
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd9,
                 16'd25, 16'd49, 16'd121, 16'd169, 16'd256, 16'd257,
                 16'd32767, 16'd32768, 16'd64009, 16'd65025, 16'd65519,
                 16'd65521, 16'd65534, 16'd65535, 16'haaaa, 16'h5555};
    wait (!rst);
    foreach (directed[i]) send_number(directed[i]);
    // hold off until every directed verdict is back
    drain_verdicts();

    for (chunk = 0; chunk < 4; chunk++) begin
      tx_gapless = (chunk == 1);
      rx_gapless = (chunk == 1) || (chunk == 3 && $urandom_range(0, 1) == 1);
      repeat (29) send_number(pick_number());
    end
    tx_gapless = 1'b0;
    drain_verdicts();
    repeat (50) @(posedge clk);

    $display("%0d numbers tested (%0d prime), %0d results checked, %0d mismatches",
             sent, board.primes, board.checked, board.mismatches);
    $display("covered 0/1/2/3, squares, large-factor composites, 16-bit extremes");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
